// ===== sv/sre_pkg.sv =====
// shared types and constants for the sliding rms envelope block
// no dependencies; used by sre_mult, sre_div, sre_sqrt and the top level
`timescale 1ns / 1ps

package sre_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ENV_W      = 15;
    localparam int WL_W       = 9;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // serial multiplier operand and product widths
    localparam int MUL_W   = 16;
    localparam int MUL_P_W = 2 * MUL_W;

    localparam logic [ENV_W-1:0] ENV_MAX   = 15'h7fff;
    localparam logic [WL_W-1:0]  WL_RESET  = 9'd64;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LPF_GAIN      = 1'b1;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== sv/sre_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module sre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sre_mult.sv =====
// serial unsigned multiplier, two multiplier bits per cycle
// depends on sre_pkg
`timescale 1ns / 1ps

module sre_mult (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sre_pkg::MUL_W-1:0]     op_a,
    input  logic [sre_pkg::MUL_W-1:0]     op_b,
    output logic [sre_pkg::MUL_P_W-1:0]   product,
    output sre_pkg::unit_stat_t           stat
);

    localparam int STEPS = sre_pkg::MUL_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [sre_pkg::MUL_P_W-1:0] acc_reg, acc_next;
    logic [sre_pkg::MUL_P_W-1:0] a_reg, a_next;
    logic [sre_pkg::MUL_W-1:0]   b_reg, b_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [sre_pkg::MUL_P_W-1:0] pp;

    always_comb begin
        pp = (b_reg[0] ? a_reg : '0) + (b_reg[1] ? {a_reg[sre_pkg::MUL_P_W-2:0], 1'b0} : '0);
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            a_next    = sre_pkg::MUL_P_W'(op_a);
            b_next    = op_b;
            cnt_next  = CNT_W'(STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = acc_reg + pp;
            a_next   = {a_reg[sre_pkg::MUL_P_W-3:0], 2'b00};
            b_next   = {2'b00, b_reg[sre_pkg::MUL_W-1:2]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/sre_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on sre_pkg
`timescale 1ns / 1ps

module sre_div #(
    parameter int DIVIDEND_W = 39,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output sre_pkg::unit_stat_t   stat
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb begin
        shifted   = {rem_reg, q_reg[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, d_reg};
        ge        = !diff[DIVISOR_W];
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = {q_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/sre_sqrt.sv =====
// serial floor square root, one root bit (two operand bits) per cycle
// depends on sre_pkg
`timescale 1ns / 1ps

module sre_sqrt #(
    parameter int IN_W = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [IN_W-1:0]       operand,
    output logic [IN_W/2-1:0]     root,
    output sre_pkg::unit_stat_t   stat
);

    localparam int RT_W  = IN_W / 2;
    localparam int CNT_W = $clog2(RT_W);

    logic [IN_W-1:0]  x_reg, x_next;
    logic [RT_W:0]    rem_reg, rem_next;
    logic [RT_W-1:0]  root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RT_W+1:0]  shifted;
    logic [RT_W+1:0]  trial;
    logic [RT_W+2:0]  diff;
    logic             ge;

    always_comb begin
        shifted   = {rem_reg[RT_W-1:0], x_reg[IN_W-1:IN_W-2]};
        trial     = {root_reg, 2'b01};
        diff      = {1'b0, shifted} - {1'b0, trial};
        ge        = !diff[RT_W+2];
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            x_next    = {x_reg[IN_W-3:0], 2'b00};
            rem_next  = ge ? diff[RT_W:0] : shifted[RT_W:0];
            root_next = {root_reg[RT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== sv/sliding_rms_envelope.sv =====
// top level of the sliding rms envelope detector: control sequencer and state
// depends on sre_pkg, sre_ram, sre_mult, sre_div, sre_sqrt
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+--------------------------------
// input     | s_valid / s_ready   | s_sample[15:0] signed, s_restart
// result    | m_valid / m_ready   | m_envelope[14:0]
// config    | cfg_wr_en           | cfg_index, cfg_data[15:0]
//
// an item that leaves the window not yet full is stored and its square added to the sum,
// and it yields no result; a full-window item also squares the oldest sample and subtracts
// it, and the filter product is left out when the filter is off or not yet primed: each
// square or filter product runs on the 2-bit serial multiplier, then come the bit-serial
// divide by the window length and the serial root
// a finished result waits in the output register; the next item is taken meanwhile
// and only stalls at its own output step if the previous result is still pending

module sliding_rms_envelope #(
    parameter int WINDOW_MAX = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sre_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                               s_restart,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sre_pkg::ENV_W-1:0]          m_envelope,
    input  logic                               cfg_wr_en,
    input  logic [sre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sre_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (LEN_W > sre_pkg::WL_W) ? LEN_W : sre_pkg::WL_W;
    localparam int SUM_W  = ADDR_W + 31;
    localparam int SQ_W   = SUM_W + (SUM_W % 2);
    localparam int RT_W   = SQ_W / 2;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_PREP      = 4'd1;
    localparam logic [3:0] ST_READ      = 4'd2;
    localparam logic [3:0] ST_SQN_GO    = 4'd3;
    localparam logic [3:0] ST_SQN_WAIT  = 4'd4;
    localparam logic [3:0] ST_SQO_GO    = 4'd5;
    localparam logic [3:0] ST_SQO_WAIT  = 4'd6;
    localparam logic [3:0] ST_CHECK     = 4'd7;
    localparam logic [3:0] ST_DIV_GO    = 4'd8;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd9;
    localparam logic [3:0] ST_SQRT_GO   = 4'd10;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd11;
    localparam logic [3:0] ST_FILT      = 4'd12;
    localparam logic [3:0] ST_FMUL_GO   = 4'd13;
    localparam logic [3:0] ST_FMUL_WAIT = 4'd14;
    localparam logic [3:0] ST_OUT       = 4'd15;

    logic [3:0]                       state_reg, state_next;
    logic [sre_pkg::WL_W-1:0]         wlen_reg, wlen_next;
    logic [sre_pkg::GAIN_W-1:0]       gain_reg, gain_next;
    logic [LEN_W-1:0]                 len_reg, len_next;
    logic [ADDR_W-1:0]                wp_reg, wp_next;
    logic [LEN_W-1:0]                 fill_reg, fill_next;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    logic [sre_pkg::ENV_W-1:0]        prev_reg, prev_next;
    logic                             primed_reg, primed_next;
    logic                             full_reg, full_next;
    logic [sre_pkg::SAMPLE_W-1:0]     smp_reg, smp_next;
    logic [sre_pkg::ENV_W-1:0]        x_reg, x_next;
    logic [sre_pkg::ENV_W-1:0]        y_reg, y_next;
    logic                             ge_reg, ge_next;
    logic                             m_valid_reg, m_valid_next;
    logic [sre_pkg::ENV_W-1:0]        env_reg, env_next;

    logic [CMP_W-1:0]                 wl_ext;
    logic [LEN_W-1:0]                 len_clamped;
    logic [LEN_W-1:0]                 wp_ext;
    logic [LEN_W-1:0]                 wp_inc;

    logic                             ram_wr_en, ram_rd_en;
    logic [sre_pkg::SAMPLE_W-1:0]     ram_rd_data;

    logic                             mul_start;
    logic [sre_pkg::MUL_W-1:0]        mul_a, mul_b;
    logic [sre_pkg::MUL_P_W-1:0]      mul_p;
    sre_pkg::unit_stat_t              mul_stat;

    logic                             div_start;
    logic [SUM_W-1:0]                 div_q;
    sre_pkg::unit_stat_t              div_stat;

    logic                             sqrt_start;
    logic [RT_W-1:0]                  sqrt_root;
    sre_pkg::unit_stat_t              sqrt_stat;

    logic [sre_pkg::MUL_W-1:0]        new_mag, old_mag;
    logic [sre_pkg::ENV_W-1:0]        fdiff;
    logic [sre_pkg::ENV_W-1:0]        fmag;
    logic                             take_in;

    // magnitude of a two's complement sample; the most negative value maps to 0x8000
    always_comb begin
        new_mag = smp_reg[sre_pkg::SAMPLE_W-1] ? (~smp_reg + 1'b1) : smp_reg;
        old_mag = ram_rd_data[sre_pkg::SAMPLE_W-1] ? (~ram_rd_data + 1'b1) : ram_rd_data;
    end

    // out-of-range window length clamps to 1 .. WINDOW_MAX
    always_comb begin
        wl_ext = CMP_W'(wlen_reg);
        if (wl_ext == '0) begin
            len_clamped = LEN_W'(1);
        end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
            len_clamped = LEN_W'(WINDOW_MAX);
        end else begin
            len_clamped = LEN_W'(wl_ext);
        end
    end

    assign wp_ext  = LEN_W'(wp_reg);
    assign wp_inc  = wp_ext + 1'b1;
    assign fdiff   = ge_reg ? (x_reg - prev_reg) : (prev_reg - x_reg);
    assign fmag    = mul_p[sre_pkg::GAIN_W+sre_pkg::ENV_W-1:sre_pkg::GAIN_W];
    assign s_ready = (state_reg == ST_IDLE);
    assign take_in = s_valid && s_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQN_GO: begin
                mul_a = new_mag;
                mul_b = new_mag;
            end
            ST_SQO_GO: begin
                mul_a = old_mag;
                mul_b = old_mag;
            end
            ST_FMUL_GO: begin
                mul_a = gain_reg;
                mul_b = sre_pkg::MUL_W'(fdiff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start  = (state_reg == ST_SQN_GO) || (state_reg == ST_SQO_GO) ||
                        (state_reg == ST_FMUL_GO);
    assign div_start  = (state_reg == ST_DIV_GO);
    assign sqrt_start = (state_reg == ST_SQRT_GO);
    assign ram_rd_en  = (state_reg == ST_READ);
    assign ram_wr_en  = (state_reg == ST_SQN_GO);

    always_comb begin
        state_next   = state_reg;
        wlen_next    = wlen_reg;
        gain_next    = gain_reg;
        len_next     = len_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        prev_next    = prev_reg;
        primed_next  = primed_reg;
        full_next    = full_reg;
        smp_next     = smp_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        ge_next      = ge_reg;
        env_next     = env_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                sre_pkg::REG_WINDOW_LENGTH: wlen_next = cfg_data[sre_pkg::WL_W-1:0];
                sre_pkg::REG_LPF_GAIN:      gain_next = cfg_data[sre_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (take_in) begin
                    smp_next = s_sample;
                    len_next = len_clamped;
                    if (s_restart) begin
                        wp_next     = '0;
                        fill_next   = '0;
                        sum_next    = '0;
                        prev_next   = '0;
                        primed_next = 1'b0;
                    end
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (wp_ext >= len_reg) begin
                    wp_next = '0;
                end
                state_next = ST_READ;
            end
            ST_READ: begin
                full_next  = (fill_reg >= len_reg);
                state_next = ST_SQN_GO;
            end
            ST_SQN_GO: begin
                state_next = ST_SQN_WAIT;
            end
            ST_SQN_WAIT: begin
                if (mul_stat.done) begin
                    sum_next = sum_reg + SUM_W'(mul_p);
                    wp_next  = (wp_inc >= len_reg) ? '0 : ADDR_W'(wp_inc);
                    if (full_reg) begin
                        state_next = ST_SQO_GO;
                    end else begin
                        fill_next  = fill_reg + 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SQO_GO: begin
                state_next = ST_SQO_WAIT;
            end
            ST_SQO_WAIT: begin
                if (mul_stat.done) begin
                    sum_next   = sum_reg - SUM_W'(mul_p);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = (fill_reg >= len_reg) ? ST_DIV_GO : ST_IDLE;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_stat.done) begin
                    if (sqrt_root > RT_W'(sre_pkg::ENV_MAX)) begin
                        x_next = sre_pkg::ENV_MAX;
                    end else begin
                        x_next = sqrt_root[sre_pkg::ENV_W-1:0];
                    end
                    state_next = ST_FILT;
                end
            end
            ST_FILT: begin
                if ((gain_reg != '0) && primed_reg) begin
                    ge_next    = (x_reg >= prev_reg);
                    state_next = ST_FMUL_GO;
                end else begin
                    y_next     = x_reg;
                    state_next = ST_OUT;
                end
            end
            ST_FMUL_GO: begin
                state_next = ST_FMUL_WAIT;
            end
            ST_FMUL_WAIT: begin
                if (mul_stat.done) begin
                    y_next     = ge_reg ? (prev_reg + fmag) : (prev_reg - fmag);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold here until the previous result has been transferred
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    env_next     = y_reg;
                    prev_next    = y_reg;
                    primed_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= sre_pkg::WL_RESET;
            gain_reg    <= sre_pkg::GAIN_RESET;
            wp_reg      <= '0;
            fill_reg    <= '0;
            sum_reg     <= '0;
            prev_reg    <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wlen_reg    <= wlen_next;
            gain_reg    <= gain_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            sum_reg     <= sum_next;
            prev_reg    <= prev_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
        end
        len_reg  <= len_next;
        full_reg <= full_next;
        smp_reg  <= smp_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ge_reg   <= ge_next;
        env_reg  <= env_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_envelope = env_reg;

    sre_ram #(
        .WIDTH (sre_pkg::SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (smp_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (wp_reg),
        .rd_data (ram_rd_data)
    );

    sre_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p),
        .stat    (mul_stat)
    );

    sre_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (len_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    sre_sqrt #(
        .IN_W (SQ_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (SQ_W'(div_q)),
        .root    (sqrt_root),
        .stat    (sqrt_stat)
    );

    // the serial units take turns and never run at the same time
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({mul_stat.busy, div_stat.busy, sqrt_stat.busy}))
        else $error("more than one arithmetic unit busy");

    // the fill count never passes the store depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(WINDOW_MAX))
        else $error("fill count beyond window store depth");

    // a transfer on the input closes the input until the item is done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        take_in |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // a finished result waits while the previous one is still pending
    a_out_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=>
        (state_reg == ST_OUT && m_valid_reg))
        else $error("pending result overwritten");

endmodule
